@@ hw/rtl/servo_ramp_and_shot_driver_defines.svh @@
// ----------------------------------------------------------------------------
// servo ramp and shot driver assertion macros
// shared concurrent check forms, sampled on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SERVO_RAMP_AND_SHOT_DRIVER_DEFINES_SVH
`define SERVO_RAMP_AND_SHOT_DRIVER_DEFINES_SVH

// same-cycle implication
`define SRSD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srsd same-cycle check failed");

// next-cycle implication
`define SRSD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srsd next-cycle check failed");

`endif

@@ hw/rtl/srsd_pkg.sv @@
// ----------------------------------------------------------------------------
// srsd_pkg
// widths, angle constants and register codes of the servo ramp and shot driver
// ----------------------------------------------------------------------------
`default_nettype none

package srsd_pkg;

  // field widths
  localparam int PITCH_W    = 38;
  localparam int SPEED_W    = 20;
  localparam int DT_W       = 16;
  localparam int DUTY_W     = 10;
  localparam int SLOT_W     = 16;
  localparam int INJ_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 38;

  // speed times elapsed time, with one bit of headroom
  localparam int PROD_W = 37;
  // pitch plus ramp step, signed
  localparam int ANG_W  = 40;
  // duty numerator and shifted divisor
  localparam int NUM_W  = 50;

  // angles in nanodegrees
  localparam logic [PITCH_W-1:0] MAX_NDEG = 38'd180000000000;
  localparam logic [PITCH_W-1:0] MID_NDEG = 38'd90000000000;
  localparam logic [PITCH_W-1:0] OFS_NDEG = 38'd45000000000;

  // duty = floor(1023 * (45 deg + angle) / 1800 deg), 1023 = 2^10 - 1
  localparam int                 DUTY_SHIFT = 10;
  localparam logic [NUM_W-1:0]   DUTY_DEN   = 50'd1800000000000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED,
    CFG_SERVO_EN,
    CFG_CONT_SHOOT,
    CFG_INJ_EN,
    CFG_INJ_PERIOD,
    CFG_INJ_CMP,
    CFG_PITCH_MIN,
    CFG_PITCH_MAX
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ hw/rtl/srsd_duty_div.sv @@
// ----------------------------------------------------------------------------
// srsd_duty_div
// servo duty from pitch angle: offset, scale by 1023, restoring division by
// the constant 1800 degrees, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module srsd_duty_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [srsd_pkg::PITCH_W-1:0] angle_i,
  output logic                              done_o,
  output logic [srsd_pkg::DUTY_W-1:0]       duty_o
);
  import srsd_pkg::*;

  localparam int STEP_W = $clog2(DUTY_W);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_NUM,
    DV_DIV
  } dv_state_e;

  dv_state_e          state_q;
  logic [PITCH_W-1:0] x_q;
  logic [NUM_W-1:0]   rem_q;
  logic [NUM_W-1:0]   dv_q;
  logic [DUTY_W-1:0]  quo_q;
  logic [STEP_W-1:0]  step_q;
  logic               done_q;
  logic               ge;

  // trial subtract of the shifted divisor
  assign ge = rem_q >= dv_q;

  // sequencer, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= (state_q == DV_DIV) && (step_q == '0);
      case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            x_q     <= angle_i + OFS_NDEG;
            state_q <= DV_NUM;
          end
        end
        DV_NUM: begin
          rem_q   <= NUM_W'({x_q, {DUTY_SHIFT{1'b0}}}) - NUM_W'(x_q);
          dv_q    <= DUTY_DEN << (DUTY_W - 1);
          quo_q   <= '0;
          step_q  <= STEP_W'(DUTY_W - 1);
          state_q <= DV_DIV;
        end
        DV_DIV: begin
          if (ge) begin
            rem_q <= rem_q - dv_q;
          end
          quo_q <= {quo_q[DUTY_W-2:0], ge};
          dv_q  <= dv_q >> 1;
          if (step_q == '0) begin
            state_q <= DV_IDLE;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign duty_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/servo_ramp_and_shot_driver.sv @@
// one tick in flight at a time: the input stalls until the bit-serial speed times time
// multiply and the 10-step duty divider are through and the result is loaded
// a waiting result does not block the next input beat
// reset: registers to their defaults, upper limit 180 deg, pitch 90 deg, timer disarmed
// ----------------------------------------------------------------------------
// servo_ramp_and_shot_driver
// pitch ramp with clamp and servo duty, single-shot timer and per-slot
// shoot bits from the inject pattern, continuous or single shooting
// ----------------------------------------------------------------------------
`default_nettype none

module servo_ramp_and_shot_driver #(
  parameter int BUF_SLOTS    = 16,
  parameter int SHOT_TIME_US = 100000
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [srsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [srsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // tick input
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [srsd_pkg::DT_W-1:0]       elapsed_us_i,
  input  wire logic                            fire_i,
  // result output
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [srsd_pkg::DUTY_W-1:0]          servo_duty_o,
  output logic [srsd_pkg::SLOT_W-1:0]          shoot_bits_o,
  output logic [srsd_pkg::PITCH_W-1:0]         pitch_ndeg_o
);
  import srsd_pkg::*;

`include "servo_ramp_and_shot_driver_defines.svh"

  localparam int SHOT_W = $clog2(SHOT_TIME_US + 1);
  localparam int CMP_W  = (SHOT_W > DT_W) ? SHOT_W : DT_W;
  localparam int STEP_W = $clog2(DT_W);
  localparam logic [SHOT_W-1:0] SHOT_INIT = SHOT_W'(SHOT_TIME_US);
  localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'((32'd1 << BUF_SLOTS) - 32'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_LO,
    ST_HI,
    ST_WAIT,
    ST_DONE
  } state_e;

  // configuration registers
  logic signed [SPEED_W-1:0] speed_q;
  logic                      servo_en_q;
  logic                      cont_q;
  logic                      inj_en_q;
  logic [INJ_W-1:0]          inj_per_q;
  logic [INJ_W-1:0]          inj_cmp_q;
  logic [PITCH_W-1:0]        pmin_q;
  logic [PITCH_W-1:0]        pmax_q;

  // tick state
  state_e                    state_q;
  logic [DT_W-1:0]           dt_q;
  logic [STEP_W-1:0]         step_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ANG_W-1:0]   ang_q;
  logic [PITCH_W-1:0]        lo_q;
  logic [PITCH_W-1:0]        hi_q;
  logic [PITCH_W-1:0]        pitch_q;
  logic [SHOT_W-1:0]         shot_left_q;
  logic                      shot_armed_q;
  logic [INJ_W-1:0]          inj_cnt_q;
  logic [SLOT_W-1:0]         inj_bits_q;
  logic [DUTY_W-1:0]         duty_q;
  logic                      div_start_q;
  logic                      out_valid_q;
  logic [DUTY_W-1:0]         out_duty_q;
  logic [SLOT_W-1:0]         out_bits_q;
  logic [PITCH_W-1:0]        out_pitch_q;

  logic                      in_acc;
  logic                      out_load;
  logic signed [PROD_W-1:0]  mul_add;
  logic signed [PROD_W-1:0]  prod_d;
  logic [INJ_W:0]            cnt_inc;
  logic [INJ_W-1:0]          inj_next;
  logic                      inj_bit;
  logic                      slot_live;
  logic [SHOT_W-1:0]         shot_base;
  logic                      shot_runs;
  logic [SHOT_W-1:0]         shot_d;
  logic [PITCH_W-1:0]        lo_lim;
  logic [PITCH_W-1:0]        hi_lim;
  logic signed [ANG_W-1:0]   ang_sum;
  logic                      shoot_all;
  logic [SLOT_W-1:0]         bits_d;
  logic                      div_done;
  logic [DUTY_W-1:0]         div_duty;

  // handshakes
  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q    <= '0;
      servo_en_q <= 1'b0;
      cont_q     <= 1'b0;
      inj_en_q   <= 1'b0;
      inj_per_q  <= '0;
      inj_cmp_q  <= '0;
      pmin_q     <= '0;
      pmax_q     <= MAX_NDEG;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPEED:      speed_q    <= cfg_wdata_i[SPEED_W-1:0];
        CFG_SERVO_EN:   servo_en_q <= cfg_wdata_i[0];
        CFG_CONT_SHOOT: cont_q     <= cfg_wdata_i[0];
        CFG_INJ_EN:     inj_en_q   <= cfg_wdata_i[0];
        CFG_INJ_PERIOD: inj_per_q  <= cfg_wdata_i[INJ_W-1:0];
        CFG_INJ_CMP:    inj_cmp_q  <= cfg_wdata_i[INJ_W-1:0];
        CFG_PITCH_MIN:  pmin_q     <= cfg_wdata_i[PITCH_W-1:0];
        CFG_PITCH_MAX:  pmax_q     <= cfg_wdata_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // bit-serial multiply, elapsed time msb first
  assign mul_add = dt_q[DT_W-1] ? PROD_W'(speed_q) : '0;
  assign prod_d  = {prod_q[PROD_W-2:0], 1'b0} + mul_add;

  // inject pwm, one slot per multiply cycle
  assign cnt_inc   = {1'b0, inj_cnt_q} + (INJ_W+1)'(1);
  assign inj_next  = (cnt_inc >= {1'b0, inj_per_q}) ? '0 : cnt_inc[INJ_W-1:0];
  assign inj_bit   = inj_next < inj_cmp_q;
  assign slot_live = inj_en_q && (32'(step_q) < BUF_SLOTS);

  // single-shot timer step
  assign shot_base = (servo_en_q && fire_i) ? SHOT_INIT : shot_left_q;
  assign shot_runs = CMP_W'(shot_base) > CMP_W'(elapsed_us_i);
  assign shot_d    = shot_runs ? SHOT_W'(CMP_W'(shot_base) - CMP_W'(elapsed_us_i)) : '0;

  // limits lowered to 180 deg
  assign lo_lim = (pmin_q > MAX_NDEG) ? MAX_NDEG : pmin_q;
  assign hi_lim = (pmax_q > MAX_NDEG) ? MAX_NDEG : pmax_q;

  // ramped angle before clamping
  assign ang_sum = $signed({2'b00, pitch_q}) + ANG_W'(prod_q);

  // shoot pattern for the result
  assign shoot_all = (servo_en_q && cont_q) || (shot_armed_q && (shot_left_q != '0));
  assign bits_d    = inj_en_q ? inj_bits_q : (shoot_all ? SLOT_MASK : '0);

  // tick sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      pitch_q      <= MID_NDEG;
      shot_left_q  <= '0;
      shot_armed_q <= 1'b0;
      inj_cnt_q    <= '0;
      div_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      div_start_q <= (state_q == ST_HI);
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            dt_q   <= elapsed_us_i;
            prod_q <= '0;
            step_q <= '0;
            lo_q   <= lo_lim;
            hi_q   <= hi_lim;
            if (!servo_en_q) begin
              shot_armed_q <= 1'b0;
              shot_left_q  <= '0;
            end else begin
              shot_armed_q <= shot_armed_q || fire_i;
              shot_left_q  <= shot_d;
            end
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q     <= prod_d;
          dt_q       <= {dt_q[DT_W-2:0], 1'b0};
          inj_bits_q <= {slot_live && inj_bit, inj_bits_q[SLOT_W-1:1]};
          if (slot_live) begin
            inj_cnt_q <= inj_next;
          end
          if (step_q == STEP_W'(DT_W - 1)) begin
            state_q <= ST_ADD;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_ADD: begin
          ang_q   <= ang_sum;
          state_q <= ST_LO;
        end
        ST_LO: begin
          if (ang_q < $signed({2'b00, lo_q})) begin
            ang_q <= $signed({2'b00, lo_q});
          end
          state_q <= ST_HI;
        end
        ST_HI: begin
          if (ang_q > $signed({2'b00, hi_q})) begin
            pitch_q <= hi_q;
          end else begin
            pitch_q <= ang_q[PITCH_W-1:0];
          end
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            duty_q  <= servo_en_q ? div_duty : '0;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_duty_q  <= duty_q;
            out_bits_q  <= bits_d;
            out_pitch_q <= pitch_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // duty from the clamped angle
  srsd_duty_div u_duty_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .angle_i (pitch_q),
    .done_o  (div_done),
    .duty_o  (div_duty)
  );

  assign out_valid_o  = out_valid_q;
  assign servo_duty_o = out_duty_q;
  assign shoot_bits_o = out_bits_q;
  assign pitch_ndeg_o = out_pitch_q;

  // checks
  `SRSD_ASSERT_NXT(a_accept_starts_mul, in_valid_i && !in_stall_o, state_q == ST_MUL)
  `SRSD_ASSERT_IMP(a_pitch_in_range, 1'b1, pitch_q <= MAX_NDEG)
  `SRSD_ASSERT_NXT(a_disabled_duty_zero, out_load && !servo_en_q, servo_duty_o == '0)
  `SRSD_ASSERT_IMP(a_div_done_in_wait, div_done, state_q == ST_WAIT)

endmodule

`default_nettype wire
